// ===== src/elc_pkg.sv =====
// Shared widths, codes, constants and item structures of the exit latency compensator.
`default_nettype none

package elc_pkg;

   localparam int TSC_W     = 64;
   localparam int SLOT_W    = 6;
   localparam int SLOT_SPAN = 2 ** SLOT_W;
   localparam int AVG_W     = 12;
   localparam int LAT_W     = 17;
   localparam int CTR_W     = 32;
   localparam int AVG_SUM_W = 15;
   localparam int AVG_SHIFT = 3;

   localparam logic [LAT_W-1:0]     MIN_EXIT   = 17'd64;
   localparam logic [LAT_W-1:0]     MAX_EXIT   = 17'd100000;
   localparam logic [AVG_W-1:0]     MAX_ADJUST = 12'd3000;
   localparam logic [AVG_SUM_W-1:0] AVG_WEIGHT = 15'd7;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 1'b0
   } csr_reg_type;

   typedef enum logic [1:0] {
      FUNC_EXIT_START  = 2'd0,
      FUNC_EXIT_FINISH = 2'd1,
      FUNC_COMPENSATE  = 2'd2
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [TSC_W-1:0]   now_tsc;
      logic [TSC_W-1:0]   guest_raw_tsc;
   } item_type;

   typedef struct packed {
      logic [TSC_W-1:0] out_tsc;
      logic             sample_taken;
      logic [AVG_W-1:0] avg_exit;
      logic [LAT_W-1:0] last_exit;
      logic [CTR_W-1:0] samples;
      logic [CTR_W-1:0] ignored;
      logic [CTR_W-1:0] compensations;
      logic [CTR_W-1:0] mono_clamps;
      logic             enabled_now;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic fire;
   } stage_ctl_type;

endpackage

`default_nettype wire

// ===== src/elc_ifs.sv =====
// Item channel interfaces for the request and response sides.
`default_nettype none

interface elc_req_if
   import elc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [SLOT_W-1:0] slot;
   logic [TSC_W-1:0]  now_tsc;
   logic [TSC_W-1:0]  guest_raw_tsc;

   modport source (output valid, func, slot, now_tsc, guest_raw_tsc, input ready);
   modport sink (input valid, func, slot, now_tsc, guest_raw_tsc, output ready);
endinterface

interface elc_rsp_if
   import elc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [TSC_W-1:0] out_tsc;
   logic             sample_taken;
   logic [AVG_W-1:0] avg_exit;
   logic [LAT_W-1:0] last_exit;
   logic [CTR_W-1:0] samples;
   logic [CTR_W-1:0] ignored;
   logic [CTR_W-1:0] compensations;
   logic [CTR_W-1:0] mono_clamps;
   logic             enabled_now;

   modport source (output valid, out_tsc, sample_taken, avg_exit, last_exit, samples,
                   ignored, compensations, mono_clamps, enabled_now, input ready);
   modport sink (input valid, out_tsc, sample_taken, avg_exit, last_exit, samples,
                 ignored, compensations, mono_clamps, enabled_now, output ready);
endinterface

`default_nettype wire

// ===== src/exit_latency_tsc_compensator_unit.sv =====
// Top level of the exit latency timestamp compensator.
// An accepted item waits in the input register, and its result then waits in the result register.
// Throughput: one item per cycle unless the response side stalls; both registers hold an item.
// The slot stores are single write port RAMs whose registered read starts at acceptance.
// Reset clears the enable register, every slot mark, the average and all statistics counters.
// Slot entries never written read as zero, so no clearing pass is needed after reset.
`default_nettype none

module exit_latency_tsc_compensator_unit
   import elc_pkg::*;
#(
   parameter int PROC_SLOTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   elc_req_if.sink                    req_chan,
   elc_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   localparam int SLOT_AW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;

   logic [SLOT_AW-1:0] slot_map [SLOT_SPAN];
   logic [SLOT_AW-1:0] rd_slot;
   logic               enable_ff;
   csr_reg_type        csr_reg;
   logic               csr_write;

   logic               s1_valid_ff, s1_valid_in;
   item_type           s1_item_ff;
   logic [SLOT_AW-1:0] s1_slot_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            core_result;
   stage_ctl_type      ctl;
   logic               out_free;

   for (genvar i = 0; i < SLOT_SPAN; i++) begin : g_slot_map
      localparam int SlotIdx = i % PROC_SLOTS;
      assign slot_map[i] = SLOT_AW'(SlotIdx);
   end

   assign rd_slot = slot_map[req_chan.slot];

   assign csr_pready = 1'b1;
   assign csr_reg    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_reg)
         CSR_ENABLE: csr_prdata = CSR_DATA_W'(enable_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write && csr_reg == CSR_ENABLE) begin
         enable_ff <= csr_pwdata[0];
      end
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign ctl.accept     = req_chan.valid && req_chan.ready;
   assign ctl.fire       = s1_valid_ff && out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ctl.accept) begin
         s1_valid_in = 1'b1;
      end else if (ctl.fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (ctl.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         s1_item_ff.func          <= func_type'(req_chan.func);
         s1_item_ff.now_tsc       <= req_chan.now_tsc;
         s1_item_ff.guest_raw_tsc <= req_chan.guest_raw_tsc;
         s1_slot_ff               <= rd_slot;
      end
      if (ctl.fire) begin
         rsp_data_ff <= core_result;
      end
   end

   elc_core #(.PROC_SLOTS(PROC_SLOTS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_slot   (rd_slot),
      .item      (s1_item_ff),
      .item_slot (s1_slot_ff),
      .enable    (enable_ff),
      .result    (core_result)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_tsc       = rsp_data_ff.out_tsc;
   assign rsp_chan.sample_taken  = rsp_data_ff.sample_taken;
   assign rsp_chan.avg_exit      = rsp_data_ff.avg_exit;
   assign rsp_chan.last_exit     = rsp_data_ff.last_exit;
   assign rsp_chan.samples       = rsp_data_ff.samples;
   assign rsp_chan.ignored       = rsp_data_ff.ignored;
   assign rsp_chan.compensations = rsp_data_ff.compensations;
   assign rsp_chan.mono_clamps   = rsp_data_ff.mono_clamps;
   assign rsp_chan.enabled_now   = rsp_data_ff.enabled_now;

`ifndef ASSERT_OFF
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.fire))
      else $error("A result appeared without an item leaving the input register.");
`endif

endmodule

`default_nettype wire

// ===== src/elc_ram.sv =====
// Generic single write port RAM with a registered read port.
`default_nettype none

module elc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/elc_core.sv =====
// Per-item measurement and compensation datapath with slot stores and statistics.
`default_nettype none

module elc_core
   import elc_pkg::*;
#(
   parameter int PROC_SLOTS = 64,
   localparam int SLOT_AW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stage_ctl_type       ctl,
   input  wire logic [SLOT_AW-1:0]  rd_slot,
   input  wire item_type            item,
   input  wire logic [SLOT_AW-1:0]  item_slot,
   input  wire logic                enable,
   output rsp_type                  result
);

   logic [TSC_W-1:0]      start_rd;
   logic [TSC_W-1:0]      guest_rd;
   logic                  start_we;
   logic                  guest_we;

   logic [PROC_SLOTS-1:0] start_written_ff, start_written_in;
   logic [PROC_SLOTS-1:0] guest_written_ff, guest_written_in;
   logic [PROC_SLOTS-1:0] exit_open_ff, exit_open_in;

   logic                  start_byp_vld_ff;
   logic [SLOT_AW-1:0]    start_byp_addr_ff;
   logic [TSC_W-1:0]      start_byp_data_ff;
   logic                  guest_byp_vld_ff;
   logic [SLOT_AW-1:0]    guest_byp_addr_ff;
   logic [TSC_W-1:0]      guest_byp_data_ff;

   logic [AVG_W-1:0]      average_ff, average_in;
   logic [LAT_W-1:0]      last_lat_ff, last_lat_in;
   logic [CTR_W-1:0]      sample_ctr_ff, sample_ctr_in;
   logic [CTR_W-1:0]      ignore_ctr_ff, ignore_ctr_in;
   logic [CTR_W-1:0]      comp_ctr_ff, comp_ctr_in;
   logic [CTR_W-1:0]      clamp_ctr_ff, clamp_ctr_in;

   logic [TSC_W-1:0]      start_val;
   logic [TSC_W-1:0]      guest_val;
   logic                  finish_stale;
   logic [TSC_W-1:0]      lat_full;
   logic [LAT_W-1:0]      lat;
   logic                  lat_in_range;
   logic [AVG_W-1:0]      lat_clamped;
   logic [AVG_SUM_W-1:0]  avg_sum;
   logic [AVG_W-1:0]      avg_next;
   logic [AVG_W-1:0]      adjust;
   logic [TSC_W-1:0]      comp_sub;
   logic                  mono_force;
   logic [TSC_W-1:0]      comp_val;
   logic [TSC_W-1:0]      out_tsc;
   logic                  taken;

   elc_ram #(.WIDTH(TSC_W), .DEPTH(PROC_SLOTS)) u_start_ram (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (item_slot),
      .wr_data (item.now_tsc),
      .rd_en   (ctl.accept),
      .rd_addr (rd_slot),
      .rd_data (start_rd)
   );

   elc_ram #(.WIDTH(TSC_W), .DEPTH(PROC_SLOTS)) u_guest_ram (
      .clock   (clock),
      .wr_en   (guest_we),
      .wr_addr (item_slot),
      .wr_data (comp_val),
      .rd_en   (ctl.accept),
      .rd_addr (rd_slot),
      .rd_data (guest_rd)
   );

   // A write made at the edge that accepted this item is not yet in the registered read data.
   always_comb begin
      if (!start_written_ff[item_slot]) begin
         start_val = '0;
      end else if (start_byp_vld_ff && start_byp_addr_ff == item_slot) begin
         start_val = start_byp_data_ff;
      end else begin
         start_val = start_rd;
      end
      if (!guest_written_ff[item_slot]) begin
         guest_val = '0;
      end else if (guest_byp_vld_ff && guest_byp_addr_ff == item_slot) begin
         guest_val = guest_byp_data_ff;
      end else begin
         guest_val = guest_rd;
      end
   end

   always_comb begin
      finish_stale = !exit_open_ff[item_slot] || start_val == '0 || item.now_tsc <= start_val;
      lat_full     = item.now_tsc - start_val;
      lat          = lat_full[LAT_W-1:0];
      lat_in_range = lat_full[TSC_W-1:LAT_W] == '0 && lat >= MIN_EXIT && lat <= MAX_EXIT;
      lat_clamped  = (lat > LAT_W'(MAX_ADJUST)) ? MAX_ADJUST : lat[AVG_W-1:0];
      avg_sum      = AVG_SUM_W'(average_ff) * AVG_WEIGHT + AVG_SUM_W'(lat_clamped);
      avg_next     = (average_ff == '0) ? lat_clamped : avg_sum[AVG_SHIFT +: AVG_W];
      adjust       = (average_ff > MAX_ADJUST) ? MAX_ADJUST : average_ff;
      comp_sub     = (item.guest_raw_tsc > TSC_W'(adjust)) ?
                     item.guest_raw_tsc - TSC_W'(adjust) : item.guest_raw_tsc;
      mono_force   = comp_sub <= guest_val;
      comp_val     = mono_force ? guest_val + TSC_W'(1) : comp_sub;
   end

   always_comb begin
      start_written_in = start_written_ff;
      guest_written_in = guest_written_ff;
      exit_open_in     = exit_open_ff;
      average_in       = average_ff;
      last_lat_in      = last_lat_ff;
      sample_ctr_in    = sample_ctr_ff;
      ignore_ctr_in    = ignore_ctr_ff;
      comp_ctr_in      = comp_ctr_ff;
      clamp_ctr_in     = clamp_ctr_ff;
      start_we         = 1'b0;
      guest_we         = 1'b0;
      out_tsc          = '0;
      taken            = 1'b0;
      case (item.func)
         FUNC_EXIT_START: begin
            if (enable) begin
               start_we                    = ctl.fire;
               start_written_in[item_slot] = 1'b1;
               exit_open_in[item_slot]     = 1'b1;
            end
         end
         FUNC_EXIT_FINISH: begin
            if (enable) begin
               if (finish_stale) begin
                  ignore_ctr_in = ignore_ctr_ff + CTR_W'(1);
               end else begin
                  exit_open_in[item_slot] = 1'b0;
                  if (!lat_in_range) begin
                     ignore_ctr_in = ignore_ctr_ff + CTR_W'(1);
                  end else begin
                     last_lat_in   = lat;
                     average_in    = avg_next;
                     sample_ctr_in = sample_ctr_ff + CTR_W'(1);
                     taken         = 1'b1;
                  end
               end
            end
         end
         FUNC_COMPENSATE: begin
            if (!enable) begin
               out_tsc = item.guest_raw_tsc;
            end else begin
               guest_we                    = ctl.fire;
               guest_written_in[item_slot] = 1'b1;
               comp_ctr_in                 = comp_ctr_ff + CTR_W'(1);
               out_tsc                     = comp_val;
               if (mono_force) begin
                  clamp_ctr_in = clamp_ctr_ff + CTR_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.out_tsc       = out_tsc;
      result.sample_taken  = taken;
      result.avg_exit      = average_in;
      result.last_exit     = last_lat_in;
      result.samples       = sample_ctr_in;
      result.ignored       = ignore_ctr_in;
      result.compensations = comp_ctr_in;
      result.mono_clamps   = clamp_ctr_in;
      result.enabled_now   = enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_written_ff <= '0;
         guest_written_ff <= '0;
         exit_open_ff     <= '0;
         average_ff       <= '0;
         last_lat_ff      <= '0;
         sample_ctr_ff    <= '0;
         ignore_ctr_ff    <= '0;
         comp_ctr_ff      <= '0;
         clamp_ctr_ff     <= '0;
         start_byp_vld_ff <= 1'b0;
         guest_byp_vld_ff <= 1'b0;
      end else if (ctl.fire) begin
         start_written_ff <= start_written_in;
         guest_written_ff <= guest_written_in;
         exit_open_ff     <= exit_open_in;
         average_ff       <= average_in;
         last_lat_ff      <= last_lat_in;
         sample_ctr_ff    <= sample_ctr_in;
         ignore_ctr_ff    <= ignore_ctr_in;
         comp_ctr_ff      <= comp_ctr_in;
         clamp_ctr_ff     <= clamp_ctr_in;
         if (start_we) begin
            start_byp_vld_ff <= 1'b1;
         end
         if (guest_we) begin
            guest_byp_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_byp_addr_ff <= item_slot;
         start_byp_data_ff <= item.now_tsc;
      end
      if (guest_we) begin
         guest_byp_addr_ff <= item_slot;
         guest_byp_data_ff <= comp_val;
      end
   end

`ifndef ASSERT_OFF
   a_sample_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && taken) |=> sample_ctr_ff == $past(sample_ctr_ff) + CTR_W'(1))
      else $error("Sample counter did not advance after an accepted sample.");

   a_disabled_frozen: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && !enable) |=> $stable(average_ff) && $stable(ignore_ctr_ff) &&
                                $stable(comp_ctr_ff) && $stable(exit_open_ff))
      else $error("State changed while measurement was disabled.");

   a_comp_written: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && enable && item.func == FUNC_COMPENSATE) |=>
         guest_byp_vld_ff && guest_byp_data_ff == $past(result.out_tsc))
      else $error("Compensated timestamp was not recorded for its slot.");
`endif

endmodule

`default_nettype wire
